/* src/tvss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_pkg
// Shared types, widths and codes for the triangle vertex snap store.
// ----------------------------------------------------------------------------
package tvss_pkg;

    // coordinate and threshold widths (signed / unsigned Q15.8)
    localparam int COORD_BITS  = 24;
    localparam int THRESH_BITS = 23;
    localparam int DIST_BITS   = (COORD_BITS + 2 > THRESH_BITS) ? COORD_BITS + 2 : THRESH_BITS;

    // default store size in triangles
    localparam int DEF_MAX_TRIANGLES = 256;

    // register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(128);
    localparam logic REG_SNAP_THRESHOLD = 1'b0;   // paddr[2], byte address 0

    // command codes
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vertex;

    typedef struct packed {
        logic   func;
        t_coord new_ax;
        t_coord new_ay;
        t_coord new_az;
        t_coord new_bx;
        t_coord new_by;
        t_coord new_bz;
        t_coord new_cx;
        t_coord new_cy;
        t_coord new_cz;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        t_coord     out_ax;
        t_coord     out_ay;
        t_coord     out_az;
        t_coord     out_bx;
        t_coord     out_by;
        t_coord     out_bz;
        t_coord     out_cx;
        t_coord     out_cy;
        t_coord     out_cz;
    } t_result;

    // control from the sequencer to the merge stage
    typedef struct packed {
        logic       fin;
        logic       rem;
        logic [1:0] status;
    } t_merge_ctl;

endpackage

/* src/tvss_vstore.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_vstore
// Vertex memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tvss_vstore
    import tvss_pkg::*;
#(
    parameter int DEPTH = 3 * DEF_MAX_TRIANGLES,
    parameter int AW    = $clog2(3 * DEF_MAX_TRIANGLES)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_vertex       i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_vertex       o_rdata
);

    t_vertex r_mem [DEPTH];
    t_vertex r_rdata;

    // write one vertex
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read one vertex, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tvss_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_lane
// One snap lane: holds a new vertex and moves it onto each stored vertex
// that lies closer than the threshold in Manhattan distance.
// ----------------------------------------------------------------------------
module tvss_lane
    import tvss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_load,
    input  t_vertex                i_load_pos,
    input  logic                   i_upd,
    input  t_vertex                i_stored,
    input  logic [THRESH_BITS-1:0] i_thresh,
    output t_vertex                o_pos
);

    t_vertex r_pos;
    t_vertex n_pos;

    logic signed [COORD_BITS:0] dx, dy, dz;
    logic signed [COORD_BITS:0] ndx, ndy, ndz;
    logic [COORD_BITS-1:0]      ax, ay, az;
    logic [DIST_BITS-1:0]       gap_sum;
    logic                       hit;

    // absolute differences per axis (both directions side by side), then the sum
    always_comb begin
        dx   = {i_stored.x[COORD_BITS-1], i_stored.x} - {r_pos.x[COORD_BITS-1], r_pos.x};
        dy   = {i_stored.y[COORD_BITS-1], i_stored.y} - {r_pos.y[COORD_BITS-1], r_pos.y};
        dz   = {i_stored.z[COORD_BITS-1], i_stored.z} - {r_pos.z[COORD_BITS-1], r_pos.z};
        ndx  = {r_pos.x[COORD_BITS-1], r_pos.x} - {i_stored.x[COORD_BITS-1], i_stored.x};
        ndy  = {r_pos.y[COORD_BITS-1], r_pos.y} - {i_stored.y[COORD_BITS-1], i_stored.y};
        ndz  = {r_pos.z[COORD_BITS-1], r_pos.z} - {i_stored.z[COORD_BITS-1], i_stored.z};
        ax   = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
        ay   = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
        az   = dz[COORD_BITS] ? ndz[COORD_BITS-1:0] : dz[COORD_BITS-1:0];
        gap_sum = DIST_BITS'(ax) + DIST_BITS'(ay) + DIST_BITS'(az);
        hit  = gap_sum < DIST_BITS'(i_thresh);
    end

    // load a new vertex, or snap onto the stored one on a hit
    always_comb begin
        n_pos = r_pos;
        if (i_load) begin
            n_pos = i_load_pos;
        end else if (i_upd && hit) begin
            n_pos = i_stored;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_pos = r_pos;

endmodule

/* src/tvss_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_merge
// Merge stage: gathers the three lane positions into the result word and
// picks the lane vertex to append to the store.
// ----------------------------------------------------------------------------
module tvss_merge
    import tvss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_merge_ctl i_ctl,
    input  t_vertex    i_lane_pos [3],
    input  logic [1:0] i_wsel,
    output t_vertex    o_wdata,
    output logic       o_done,
    output t_result    o_result
);

    logic    r_done;
    t_result r_result;
    t_result n_result;

    // assemble the result word
    always_comb begin
        n_result        = '0;
        n_result.status = i_ctl.status;
        if (!i_ctl.rem) begin
            n_result.out_ax = i_lane_pos[0].x;
            n_result.out_ay = i_lane_pos[0].y;
            n_result.out_az = i_lane_pos[0].z;
            n_result.out_bx = i_lane_pos[1].x;
            n_result.out_by = i_lane_pos[1].y;
            n_result.out_bz = i_lane_pos[1].z;
            n_result.out_cx = i_lane_pos[2].x;
            n_result.out_cy = i_lane_pos[2].y;
            n_result.out_cz = i_lane_pos[2].z;
        end
    end

    // select the vertex being appended
    always_comb begin
        case (i_wsel)
            2'd0:    o_wdata = i_lane_pos[0];
            2'd1:    o_wdata = i_lane_pos[1];
            2'd2:    o_wdata = i_lane_pos[2];
            default: o_wdata = i_lane_pos[0];
        endcase
    end

    // strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.fin;
        end
    end

    // hold the result word
    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* src/triangle_vertex_snap_store_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_vertex_snap_store_core
// Triangle store with vertex snapping: an add word is snapped against all
// stored vertices in insertion order and appended unless the store is full;
// a remove word drops the last triangle.
//
//   channel   | ports                                  | direction
//   ----------+----------------------------------------+----------
//   command   | start, busy, i_cmd                     | in
//   result    | o_done, o_result                       | out
//   register  | psel, penable, pwrite, paddr, pwdata,  | in/out
//             | prdata, pready                         |
//
// An add walks the stored vertices (three per stored triangle) before its
// strobe: one stored vertex per cycle through the single memory read port,
// compared against all three new vertices in parallel lanes, then the three
// vertices are appended in turn through the write port (none on a full store).
// A remove strobes its result the cycle after accept.
// Reset empties the store at once (the count clears; memory needs no pass).
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module triangle_vertex_snap_store_core
    import tvss_pkg::*;
#(
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command
    input  logic              start,
    output logic              busy,
    input  t_cmd              i_cmd,
    // result
    output logic              o_done,
    output t_result           o_result,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int DEPTH  = 3 * MAX_TRIANGLES;
    localparam int AW     = $clog2(DEPTH);
    localparam int VCNT_W = $clog2(DEPTH + 1);
    localparam int TCNT_W = $clog2(MAX_TRIANGLES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [TCNT_W-1:0]      r_count, n_count;
    logic [VCNT_W-1:0]      r_total, n_total;
    logic [VCNT_W-1:0]      r_addr, n_addr;
    logic                   r_rd_vld;
    logic                   r_full, n_full;
    logic [1:0]             r_wk, n_wk;
    logic [THRESH_BITS-1:0] r_thresh;

    logic          accept;
    logic          load;
    logic          rd_en;
    logic          we;
    logic [AW-1:0] waddr;
    logic [VCNT_W-1:0] waddr_full;
    t_vertex       rdata;
    t_vertex       wdata;
    t_vertex       new_pos [3];
    t_vertex       lane_pos [3];
    t_merge_ctl    mctl;

    // ---------------- register port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_SNAP_THRESHOLD) begin
            r_thresh <= pwdata[THRESH_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SNAP_THRESHOLD) ? APB_DW'(r_thresh) : '0;

    // ---------------- command unpack ----------------
    assign new_pos[0] = '{x: i_cmd.new_ax, y: i_cmd.new_ay, z: i_cmd.new_az};
    assign new_pos[1] = '{x: i_cmd.new_bx, y: i_cmd.new_by, z: i_cmd.new_bz};
    assign new_pos[2] = '{x: i_cmd.new_cx, y: i_cmd.new_cy, z: i_cmd.new_cz};

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign load   = accept && (i_cmd.func == FUNC_ADD);

    // ---------------- sequencer ----------------
    assign rd_en      = (r_state == S_WALK) && (r_addr < r_total);
    assign we         = (r_state == S_WRITE);
    assign waddr_full = r_total + VCNT_W'(r_wk);
    assign waddr      = waddr_full[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_total = r_total;
        n_addr  = r_addr;
        n_full  = r_full;
        n_wk    = r_wk;
        mctl    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd.func == FUNC_REMOVE) begin
                        // drop the last triangle, or report empty
                        mctl.fin = 1'b1;
                        mctl.rem = 1'b1;
                        if (r_count == '0) begin
                            mctl.status = ST_EMPTY;
                        end else begin
                            mctl.status = ST_OK;
                            n_count     = r_count - TCNT_W'(1);
                        end
                    end else begin
                        // start the walk over 3*count stored vertices
                        n_total = VCNT_W'({r_count, 1'b0}) + VCNT_W'(r_count);
                        n_addr  = '0;
                        n_full  = (r_count == TCNT_W'(MAX_TRIANGLES));
                        n_wk    = '0;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (rd_en) begin
                    n_addr = r_addr + VCNT_W'(1);
                end else if (!r_rd_vld) begin
                    if (r_full) begin
                        mctl.fin    = 1'b1;
                        mctl.status = ST_FULL;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                // append A, B, C one per cycle
                n_wk = r_wk + 2'd1;
                if (r_wk == 2'd2) begin
                    mctl.fin    = 1'b1;
                    mctl.status = ST_OK;
                    n_count     = r_count + TCNT_W'(1);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= rd_en;
        end
    end

    // hold walk bookkeeping
    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_addr  <= n_addr;
        r_full  <= n_full;
        r_wk    <= n_wk;
    end

    // ---------------- vertex memory ----------------
    tvss_vstore #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    // ---------------- snap lanes ----------------
    for (genvar k = 0; k < 3; k++) begin : g_lane
        tvss_lane u_lane (
            .i_clk      (i_clk),
            .i_load     (load),
            .i_load_pos (new_pos[k]),
            .i_upd      (r_rd_vld),
            .i_stored   (rdata),
            .i_thresh   (r_thresh),
            .o_pos      (lane_pos[k])
        );
    end

    // ---------------- merge ----------------
    tvss_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mctl),
        .i_lane_pos (lane_pos),
        .i_wsel     (r_wk),
        .o_wdata    (wdata),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

/* dv/triangle_vertex_snap_store_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_vertex_snap_store_core_test
// Self-checking bench for the triangle vertex snap store. A short table of
// directed words comes first, then random add/remove words across several
// snap thresholds (zero, maximum, small random), and a fill of the store to
// capacity with adds bounced off the full store. Each accepted word runs
// through a local snap predictor; every result word is compared field by
// field against the oldest expected word.
// ----------------------------------------------------------------------------
module triangle_vertex_snap_store_core_test;
    import tvss_pkg::*;

    localparam int MAX_TRI     = DEF_MAX_TRIANGLES;
    localparam int CMAX        = 8388607;
    localparam int CMIN        = -8388608;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        t_cmd    cmd;
        bit      fixed;
        t_result want;
    } stim_row_t;

    // block ports
    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    t_cmd              i_cmd     = '0;
    logic              o_done;
    t_result           o_result;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // predictor state
    t_vertex                vertex_store [3*MAX_TRI];
    int                     stored_tris  = 0;
    int                     peak_tris    = 0;
    logic [THRESH_BITS-1:0] snap_thr     = THRESH_RESET;

    // expected result words, oldest first
    t_result pending_results[$];

    // directed stimulus table
    stim_row_t directed_rows[$];

    // bookkeeping
    int          mismatches    = 0;
    int          checked_words = 0;
    int          add_words     = 0;
    int          full_adds     = 0;
    int          remove_words  = 0;
    int          empty_removes = 0;
    int          thr_settings  = 1;
    bit          no_gaps       = 1'b0;
    int unsigned cycle_count   = 0;

    triangle_vertex_snap_store_core #(
        .MAX_TRIANGLES(MAX_TRI)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch: %s", $time, what);
    endfunction

    function automatic t_vertex vtx(int x, int y, int z);
        t_vertex v;
        v.x = t_coord'(x);
        v.y = t_coord'(y);
        v.z = t_coord'(z);
        return v;
    endfunction

    function automatic t_cmd mk_cmd(logic f, t_vertex a, t_vertex b, t_vertex c);
        t_cmd w;
        w.func   = f;
        w.new_ax = a.x; w.new_ay = a.y; w.new_az = a.z;
        w.new_bx = b.x; w.new_by = b.y; w.new_bz = b.z;
        w.new_cx = c.x; w.new_cy = c.y; w.new_cz = c.z;
        return w;
    endfunction

    function automatic t_result mk_res(logic [1:0] st, t_vertex a, t_vertex b,
                                       t_vertex c);
        t_result r;
        r.status = st;
        r.out_ax = a.x; r.out_ay = a.y; r.out_az = a.z;
        r.out_bx = b.x; r.out_by = b.y; r.out_bz = b.z;
        r.out_cx = c.x; r.out_cy = c.y; r.out_cz = c.z;
        return r;
    endfunction

    // Append one row to the directed table.
    function automatic void add_row(t_cmd c, bit fixed, t_result want);
        stim_row_t row;
        row.cmd       = c;
        row.fixed     = fixed;
        row.want      = want;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic longint axis_gap(t_coord a, t_coord b);
        longint t;
        t = longint'(a) - longint'(b);
        return (t < 0) ? -t : t;
    endfunction

    // Snap the new triangle against the store in insertion order, then append it.
    function automatic t_result snap_and_store(t_cmd c);
        t_result r;
        t_vertex v [3];
        t_vertex s;
        longint  d;
        r = '0;
        if (c.func == FUNC_REMOVE) begin
            remove_words++;
            if (stored_tris == 0) begin
                r.status = ST_EMPTY;
                empty_removes++;
            end else begin
                stored_tris--;
                r.status = ST_OK;
            end
            return r;
        end
        add_words++;
        v[0] = vtx(c.new_ax, c.new_ay, c.new_az);
        v[1] = vtx(c.new_bx, c.new_by, c.new_bz);
        v[2] = vtx(c.new_cx, c.new_cy, c.new_cz);
        for (int i = 0; i < 3*stored_tris; i++) begin
            s = vertex_store[i];
            for (int k = 0; k < 3; k++) begin
                d = axis_gap(s.x, v[k].x) + axis_gap(s.y, v[k].y) + axis_gap(s.z, v[k].z);
                // strictly below only; a later match overrides
                if (d < longint'(snap_thr))
                    v[k] = s;
            end
        end
        if (stored_tris < MAX_TRI) begin
            for (int k = 0; k < 3; k++)
                vertex_store[3*stored_tris + k] = v[k];
            stored_tris++;
            if (stored_tris > peak_tris)
                peak_tris = stored_tris;
            r.status = ST_OK;
        end else begin
            r.status = ST_FULL;
            full_adds++;
        end
        r.out_ax = v[0].x; r.out_ay = v[0].y; r.out_az = v[0].z;
        r.out_bx = v[1].x; r.out_by = v[1].y; r.out_bz = v[1].z;
        r.out_cx = v[2].x; r.out_cy = v[2].y; r.out_cz = v[2].z;
        return r;
    endfunction

    // Mostly jitter around a stored vertex so distances straddle the threshold.
    function automatic t_vertex draw_vertex();
        t_vertex base;
        t_vertex v;
        int      pick;
        int      span;
        pick = $urandom_range(0, 9);
        if (stored_tris != 0 && pick < 6) begin
            base = vertex_store[$urandom_range(0, 3*stored_tris - 1)];
            span = (snap_thr == 0) ? 4 : ((snap_thr > 4096) ? 4096 : int'(snap_thr));
            v.x = t_coord'(int'(base.x) + int'($urandom_range(0, span)) - span/2);
            v.y = t_coord'(int'(base.y) + int'($urandom_range(0, span)) - span/2);
            v.z = t_coord'(int'(base.z) + int'($urandom_range(0, span)) - span/2);
        end else if (pick < 8) begin
            v = vtx($urandom, $urandom, $urandom);
        end else begin
            v = vtx(int'($urandom_range(0, 511)) - 256, int'($urandom_range(0, 511)) - 256,
                    int'($urandom_range(0, 511)) - 256);
        end
        return v;
    endfunction

    function automatic t_cmd make_cmd(logic f);
        t_vertex a;
        t_vertex b;
        t_vertex c;
        a = draw_vertex();
        b = draw_vertex();
        c = draw_vertex();
        return mk_cmd(f, a, b, c);
    endfunction

    // Offer one word after a random gap, hold it until accepted, then predict.
    task automatic issue_word(t_cmd c, bit fixed, t_result want);
        int      gap;
        t_result r;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 23) == 0)
            no_gaps = !no_gaps;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = snap_and_store(c);
        pending_results = {pending_results, (fixed ? want : r)};
    endtask

    // Hold off the sender until every expected word is back and the block idles.
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy !== 1'b0);
    endtask

    // Write the threshold (setup + access), then read it back.
    task automatic program_threshold(logic [THRESH_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SNAP_THRESHOLD, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        snap_thr = val;
        thr_settings++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== APB_DW'(val))
            note_mismatch($sformatf("threshold readback: expected %0d, got %0d",
                                    val, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0)
                drain_results();
            // lean toward removes once the store grows, to keep walks short
            c = make_cmd(($urandom_range(0, 99) < ((stored_tris > 24) ? 45 : 20))
                         ? FUNC_REMOVE : FUNC_ADD);
            issue_word(c, 1'b0, '0);
        end
    endtask

    // Compare each result word with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result                   want;
        logic [9*COORD_BITS-1:0]   got_c;
        logic [9*COORD_BITS-1:0]   want_c;
        string                     names [9];
        names = '{"out_ax", "out_ay", "out_az", "out_bx", "out_by", "out_bz",
                  "out_cx", "out_cy", "out_cz"};
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result word with nothing expected");
            end else begin
                want = pending_results.pop_front();
                checked_words++;
                if (o_result.status !== want.status)
                    note_mismatch($sformatf("status: expected %0d, got %0d",
                                            want.status, o_result.status));
                got_c  = o_result[9*COORD_BITS-1:0];
                want_c = want[9*COORD_BITS-1:0];
                for (int j = 0; j < 9; j++) begin
                    if (got_c[(9-j)*COORD_BITS-1 -: COORD_BITS] !==
                        want_c[(9-j)*COORD_BITS-1 -: COORD_BITS])
                        note_mismatch($sformatf("%s: expected %0d, got %0d", names[j],
                            t_coord'(want_c[(9-j)*COORD_BITS-1 -: COORD_BITS]),
                            t_coord'(got_c[(9-j)*COORD_BITS-1 -: COORD_BITS])));
                end
            end
        end
    end

    initial begin : stimulus
        t_vertex   vmax;
        t_vertex   vmin;
        t_vertex   zv;
        vmax = vtx(CMAX, CMAX, CMAX);
        vmin = vtx(CMIN, CMIN, CMIN);
        zv   = vtx(0, 0, 0);

        // remove on an empty store, first add, exact re-add
        add_row(mk_cmd(FUNC_REMOVE, vtx(5, 6, 7), vtx(-8, 9, -10), vtx(CMAX, CMIN, 1)),
                1'b1, mk_res(ST_EMPTY, zv, zv, zv));
        add_row(mk_cmd(FUNC_ADD, vmax, vmin, zv), 1'b1, mk_res(ST_OK, vmax, vmin, zv));
        add_row(mk_cmd(FUNC_ADD, vmax, vmin, zv), 1'b1, mk_res(ST_OK, vmax, vmin, zv));
        // distances one under and exactly at the threshold
        add_row(mk_cmd(FUNC_ADD, vtx(127, 0, 0), vtx(128, 0, 0),
                       vtx(CMAX, CMAX, CMAX - 67)), 1'b0, '0);
        add_row(mk_cmd(FUNC_ADD, vtx(40, 40, 48), vtx(40, 40, 47),
                       vtx(-40, -40, -48)), 1'b0, '0);
        add_row(mk_cmd(FUNC_ADD, vtx(60, 0, 0), vtx(100, 20, 0),
                       vtx(-50, -50, -27)), 1'b0, '0);
        add_row(mk_cmd(FUNC_ADD, vtx(-1, 0, 1), vtx(CMIN, CMAX, -1),
                       vtx(CMIN + 100, CMIN, CMIN)), 1'b0, '0);
        // successful removes return zero coordinates
        add_row(mk_cmd(FUNC_REMOVE, vmax, vmin, vmax), 1'b1, mk_res(ST_OK, zv, zv, zv));
        add_row(mk_cmd(FUNC_REMOVE, vmin, vmax, vmin), 1'b1, mk_res(ST_OK, zv, zv, zv));
        add_row(mk_cmd(FUNC_ADD, vtx(1000, -1000, 1000), vtx(CMAX, 0, CMIN),
                       vtx(0, CMIN, CMAX)), 1'b0, '0);
        add_row(mk_cmd(FUNC_ADD, vtx(CMAX - 63, CMIN + 64, -1), vtx(-128, 0, 0),
                       vtx(0, -127, 0)), 1'b0, '0);
        // alternating bit patterns
        add_row(mk_cmd(FUNC_ADD, vtx(5592405, -5592406, 5592405),
                       vtx(-5592406, 5592405, -5592406), zv), 1'b0, '0);
        add_row(mk_cmd(FUNC_REMOVE, zv, zv, zv), 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at the reset threshold
        foreach (directed_rows[i])
            issue_word(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].want);
        drain_results();

        // nothing snaps
        program_threshold('0);
        run_random(45);
        drain_results();

        // widest threshold
        program_threshold({THRESH_BITS{1'b1}});
        run_random(45);
        drain_results();

        program_threshold(THRESH_BITS'($urandom_range(1, 4096)));
        run_random(70);
        drain_results();

        // fill to capacity, bounce adds off the full store, then back off
        program_threshold(THRESH_BITS'($urandom_range(64, 1024)));
        while (stored_tris < MAX_TRI)
            issue_word(make_cmd(FUNC_ADD), 1'b0, '0);
        repeat (4) issue_word(make_cmd(FUNC_ADD), 1'b0, '0);
        repeat (20) issue_word(make_cmd(FUNC_REMOVE), 1'b0, '0);
        drain_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d adds (%0d on a full store) and %0d removes (%0d on empty),",
                 add_words, full_adds, remove_words, empty_removes);
        $display("%0d threshold settings, store peak %0d triangles, %0d words checked",
                 thr_settings, peak_tris, checked_words);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* triangle_vertex_snap_store_core.f */
src/tvss_pkg.sv
src/tvss_vstore.sv
src/tvss_lane.sv
src/tvss_merge.sv
src/triangle_vertex_snap_store_core.sv
dv/triangle_vertex_snap_store_core_test.sv
